// ===== src/acs_pkg.sv =====
// Package of shared types, codes and helpers for the accumulator machine.
package acs_pkg;

   localparam int MEM_DEPTH = 128;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int VALUE_W   = 32;
   localparam int ADDR_W    = 7;
   localparam int CODE_W    = 3;
   localparam int MODE_W    = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD = 2'd0,
      MODE_EXEC = 2'd1,
      MODE_READ = 2'd2
   } mode_type;

   typedef enum logic [CODE_W-1:0] {
      OP_DAT = 3'd0,
      OP_LDA = 3'd1,
      OP_SUB = 3'd2,
      OP_STA = 3'd3,
      OP_BRZ = 3'd4,
      OP_BRA = 3'd5,
      OP_HLT = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EXEC,
      ST_READ,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type                     code;
      logic signed [VALUE_W-1:0]  value;
   } word_type;

   typedef struct packed {
      logic [MODE_W-1:0]          mode;
      logic [ADDR_W-1:0]          word_address;
      logic [CODE_W-1:0]          load_code;
      logic signed [VALUE_W-1:0]  load_value;
   } req_type;

   typedef struct packed {
      logic                       running;
      logic [ADDR_W-1:0]          program_counter;
      logic signed [VALUE_W-1:0]  accumulator;
      logic [CODE_W-1:0]          read_code;
      logic signed [VALUE_W-1:0]  read_value;
   } rsp_type;

   typedef struct packed {
      logic                       run;
      logic [MEM_AW-1:0]          pc;
      logic signed [VALUE_W-1:0]  acc;
      logic                       st_en;
      logic [MEM_AW-1:0]          st_addr;
   } exec_type;

   // A value names a memory word when it is non-negative and below the depth.
   function automatic logic oper_addr_ok(input logic signed [VALUE_W-1:0] v);
      return $unsigned(v) < VALUE_W'(MEM_DEPTH);
   endfunction

endpackage

// ===== src/acs_exec.sv =====
// Instruction execute logic: new accumulator, PC, run flag and store request.
module acs_exec import acs_pkg::*; (
   input  word_type                   inst,
   input  logic signed [VALUE_W-1:0]  opd,
   input  logic signed [VALUE_W-1:0]  acc,
   input  logic [MEM_AW-1:0]          pc,
   output exec_type                   ex
);

   logic              ok;
   logic [MEM_AW-1:0] addr;
   logic              stop;

   always_comb begin
      ok         = oper_addr_ok(inst.value);
      addr       = MEM_AW'(inst.value);
      stop       = 1'b0;
      ex.run     = 1'b1;
      ex.pc      = pc;
      ex.acc     = acc;
      ex.st_en   = 1'b0;
      ex.st_addr = addr;
      case (inst.code)
         OP_LDA: ex.acc = opd;
         OP_SUB: ex.acc = acc - opd;
         OP_STA: ex.st_en = ok;
         OP_BRZ, OP_BRA: begin
            if (inst.code == OP_BRA || acc == '0) begin
               if (ok) begin
                  ex.pc = addr;
               end else begin
                  // bad target: halt and keep the PC on the branch
                  ex.run = 1'b0;
                  stop   = 1'b1;
               end
            end
         end
         default: ex.run = 1'b0;
      endcase
      // advance the PC when the instruction left it in place; on the last word, halt instead
      if (!stop && ex.pc == pc) begin
         if (pc == MEM_AW'(MEM_DEPTH - 1)) begin
            ex.run = 1'b0;
         end else begin
            ex.pc = pc + MEM_AW'(1);
         end
      end
   end

endmodule

// ===== src/accumulator_cpu_step.sv =====
// Top level of the accumulator machine: request sequencer, word memory, result register.
// Timing: a load (or an unknown mode, or execute while halted) finishes in the transfer
// state, a read passes READ, an execute FETCH then EXEC, set by the registered memory
// read: fetch read, operand read, then commit. Throughput: one item per cycle for loads
// unless the result stalls; no new request is taken while a read or an execute runs.
// Reset: memory words read empty (valid bit per word cleared), accumulator and PC zero,
// machine running, no result pending. No clearing pass is needed.
module accumulator_cpu_step import acs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // sequencer
   state_type state_ff, state_in;

   // architectural state
   logic signed [VALUE_W-1:0] acc_ff, acc_in;
   logic [MEM_AW-1:0]         pc_ff, pc_in;
   logic                      run_ff, run_in;

   // read fields of the pending result
   logic [CODE_W-1:0]         rcode_ff, rcode_in;
   logic signed [VALUE_W-1:0] rval_ff, rval_in;

   // instruction held between fetch and execute
   word_type                  inst_ff, inst_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   // word memory with one valid bit per word; an invalid word reads empty
   word_type                  mem_ff [MEM_DEPTH];
   logic [MEM_DEPTH-1:0]      valid_ff;
   word_type                  rd_word_ff;
   logic                      rd_valid_ff;
   word_type                  rd_word;

   logic                      rd_en;
   logic [MEM_AW-1:0]         rd_addr;
   logic                      wr_en;
   logic [MEM_AW-1:0]         wr_addr;
   word_type                  wr_word;

   logic                      accept;
   logic                      simple;
   logic                      finish;
   logic                      out_free;
   logic                      load_ok;
   logic signed [VALUE_W-1:0] opd;
   exec_type                  ex;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load_ok  = 32'(req_data.word_address) < 32'(MEM_DEPTH);
   // a transfer that finishes at once: load, unknown mode, or execute while halted
   assign simple   = !(req_data.mode == MODE_READ || (req_data.mode == MODE_EXEC && run_ff));
   assign rd_word  = rd_valid_ff ? rd_word_ff : '0;
   // the operand only counts when it names a word; otherwise it reads as zero
   assign opd      = oper_addr_ok(inst_ff.value) ? rd_word.value : '0;

   acs_exec u_exec (
      .inst (inst_ff),
      .opd  (opd),
      .acc  (acc_ff),
      .pc   (pc_ff),
      .ex   (ex)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (simple) begin
                  state_in = out_free ? ST_IDLE : ST_DONE;
               end else if (req_data.mode == MODE_READ) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: state_in = ST_EXEC;
         ST_EXEC, ST_READ, ST_DONE: state_in = out_free ? ST_IDLE : ST_DONE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake, memory port, finish strobe
   always_comb begin
      req_ready = 1'b0;
      finish    = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = pc_ff;
      wr_en     = 1'b0;
      wr_addr   = MEM_AW'(req_data.word_address);
      wr_word   = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               finish = simple;
               if (req_data.mode == MODE_READ) begin
                  rd_en   = 1'b1;
                  rd_addr = MEM_AW'(req_data.word_address);
               end else if (req_data.mode == MODE_EXEC) begin
                  // fetch the instruction at the PC
                  rd_en = 1'b1;
               end else if (req_data.mode == MODE_LOAD) begin
                  wr_en        = load_ok;
                  wr_word.code = (req_data.load_code > OP_HLT) ? OP_DAT
                                                              : op_type'(req_data.load_code);
                  wr_word.value = req_data.load_value;
               end
            end
         end
         ST_FETCH: begin
            // read the operand word named by the fetched instruction
            rd_en   = 1'b1;
            rd_addr = MEM_AW'(rd_word.value);
         end
         ST_EXEC: begin
            finish        = 1'b1;
            wr_en         = ex.st_en;
            wr_addr       = ex.st_addr;
            wr_word.code  = OP_DAT;
            wr_word.value = acc_ff;
         end
         ST_READ, ST_DONE: finish = 1'b1;
         default: finish = 1'b0;
      endcase
   end

   // datapath next values
   always_comb begin
      acc_in   = acc_ff;
      pc_in    = pc_ff;
      run_in   = run_ff;
      rcode_in = rcode_ff;
      rval_in  = rval_ff;
      inst_in  = inst_ff;
      if (accept) begin
         rcode_in = '0;
         rval_in  = '0;
      end
      if (state_ff == ST_FETCH) begin
         inst_in = rd_word;
      end
      if (state_ff == ST_EXEC) begin
         acc_in = ex.acc;
         pc_in  = ex.pc;
         run_in = ex.run;
      end
      if (state_ff == ST_READ) begin
         rcode_in = rd_word.code;
         rval_in  = rd_word.value;
      end

      rsp_data_in.running         = run_in;
      rsp_data_in.program_counter = ADDR_W'(pc_in);
      rsp_data_in.accumulator     = acc_in;
      rsp_data_in.read_code       = rcode_in;
      rsp_data_in.read_value      = rval_in;

      if (finish && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         pc_ff        <= '0;
         run_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         pc_ff        <= pc_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // payload registers: hold the read fields, fetched word and result
   always_ff @(posedge clock) begin
      rcode_ff <= rcode_in;
      rval_ff  <= rval_in;
      inst_ff  <= inst_in;
      if (finish && out_free) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // word memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_word;
      end
      if (rd_en) begin
         rd_word_ff  <= mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/acs_checker.sv =====
// Port-level checker for the accumulator machine, bound to the top level.
module acs_checker import acs_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // leaving reset: ready for a transfer, no result pending
   a_reset_state: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("bad state after reset");

   // a transfer taken while the result is stalled must not be followed by another at once
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_valid && !rsp_ready |=> !req_ready)
      else $error("request taken with no room for its result");

   // stored codes never exceed the halt code
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.read_code <= OP_HLT)
      else $error("read code out of range");

endmodule

bind accumulator_cpu_step acs_checker u_acs_checker (.*);

// ===== tb/accumulator_cpu_step_test.sv =====
// Self-checking testbench for the accumulator machine: directed and random requests.
module accumulator_cpu_step_test;
   import acs_pkg::*;

   // Request fields that name no mode or no operation
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic [CODE_W-1:0] CODE_UNUSED = 3'd7;

   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
   localparam int LAST_WORD = MEM_DEPTH - 1;

   localparam int RANDOM_ITEMS = 700;
   // Cycles without any transfer before the run is given up
   localparam int QUIET_LIMIT  = 1000;
   // Cycles to watch for stray results once nothing is awaited
   localparam int DRAIN_CYCLES = 8;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Shadow copy of the machine, advanced once per request transfer
   logic [CODE_W-1:0]         shadow_code [MEM_DEPTH];
   logic signed [VALUE_W-1:0] shadow_value [MEM_DEPTH];
   logic signed [VALUE_W-1:0] shadow_acc;
   logic [ADDR_W-1:0]         shadow_pc;
   logic                      shadow_run;

   // Responses owed by the block, oldest first
   rsp_type predicted_rsp [$];

   int fault_count  = 0;
   int quiet_cycles = 0;
   // Set during the stretch in which neither side idles
   bit calm = 1'b0;

   accumulator_cpu_step i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // An operand names a memory word only when non-negative and inside memory.
   function automatic bit names_word(input logic signed [VALUE_W-1:0] opnd);
      return opnd >= 0 && opnd < MEM_DEPTH;
   endfunction

   // Advance the shadow machine by one request and return the response it owes.
   function automatic rsp_type step_machine(input req_type r);
      rsp_type                   o;
      logic [ADDR_W-1:0]         fetched;
      logic [CODE_W-1:0]         op;
      logic signed [VALUE_W-1:0] opnd;
      logic signed [VALUE_W-1:0] fetched_data;
      bit                        ok;
      bit                        branched_out;
      o = '0;
      branched_out = 1'b0;
      case (r.mode)
         MODE_LOAD: begin
            // Codes beyond HLT are kept as plain data
            shadow_code[r.word_address]  = (r.load_code > OP_HLT) ? OP_DAT : r.load_code;
            shadow_value[r.word_address] = r.load_value;
         end
         MODE_EXEC: begin
            if (shadow_run) begin
               fetched      = shadow_pc;
               op           = shadow_code[fetched];
               opnd         = shadow_value[fetched];
               ok           = names_word(opnd);
               // Operands outside memory read as zero
               fetched_data = ok ? shadow_value[opnd[ADDR_W-1:0]] : '0;
               case (op)
                  OP_LDA: shadow_acc = fetched_data;
                  OP_SUB: shadow_acc = shadow_acc - fetched_data;
                  OP_STA: begin
                     if (ok) begin
                        shadow_code[opnd[ADDR_W-1:0]]  = OP_DAT;
                        shadow_value[opnd[ADDR_W-1:0]] = shadow_acc;
                     end
                  end
                  OP_BRZ, OP_BRA: begin
                     if (op == OP_BRA || shadow_acc == 0) begin
                        if (ok) begin
                           shadow_pc = opnd[ADDR_W-1:0];
                        end else begin
                           // Target outside memory: halt and keep the branch address
                           shadow_run   = 1'b0;
                           branched_out = 1'b1;
                        end
                     end
                  end
                  default: shadow_run = 1'b0;
               endcase
               // An untouched PC advances, even after a branch to itself or a halt; the last word halts instead
               if (!branched_out && shadow_pc == fetched) begin
                  if (fetched == LAST_WORD) begin
                     shadow_run = 1'b0;
                  end else begin
                     shadow_pc = fetched + 1'b1;
                  end
               end
            end
         end
         MODE_READ: begin
            o.read_code  = shadow_code[r.word_address];
            o.read_value = shadow_value[r.word_address];
         end
         default: ;
      endcase
      o.running         = shadow_run;
      o.program_counter = shadow_pc;
      o.accumulator     = shadow_acc;
      return o;
   endfunction

   // Tell whether executing this word at the current PC would stop the machine.
   function automatic bit would_halt(input logic [CODE_W-1:0] op,
                                     input logic signed [VALUE_W-1:0] opnd);
      bit at_end;
      bit taken;
      at_end = (shadow_pc == LAST_WORD);
      taken  = (op == OP_BRA) || (op == OP_BRZ && shadow_acc == 0);
      case (op)
         OP_LDA, OP_SUB, OP_STA: return at_end;
         OP_BRZ, OP_BRA: begin
            if (!taken) return at_end;
            if (!names_word(opnd)) return 1'b1;
            return opnd[ADDR_W-1:0] == shadow_pc && at_end;
         end
         default: return 1'b1;
      endcase
   endfunction

   function automatic req_type build_request(input logic [MODE_W-1:0] m,
                                             input logic [ADDR_W-1:0] a,
                                             input logic [CODE_W-1:0] c,
                                             input logic signed [VALUE_W-1:0] v);
      req_type r;
      r.mode         = m;
      r.word_address = a;
      r.load_code    = c;
      r.load_value   = v;
      return r;
   endfunction

   // Fields the mode does not use still carry random content.
   function automatic req_type random_request(input logic [MODE_W-1:0] m);
      return build_request(m, ADDR_W'($urandom), CODE_W'($urandom), $urandom);
   endfunction

   // Mostly operands that name a word, now and then any value at all.
   function automatic logic signed [VALUE_W-1:0] random_operand();
      if ($urandom_range(3) == 0) return $urandom;
      return $urandom_range(LAST_WORD);
   endfunction

   // Offer one request, idling now and then first, and hold it until the transfer.
   task automatic send_request(input req_type r);
      while (!calm && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      predicted_rsp.push_back(step_machine(r));
   endtask

   // Overwrite the word at the PC until it lets the machine keep running.
   task automatic keep_running();
      logic [CODE_W-1:0]         op;
      logic signed [VALUE_W-1:0] opnd;
      while (would_halt(shadow_code[shadow_pc], shadow_value[shadow_pc])) begin
         op   = CODE_W'($urandom_range(OP_BRA, OP_LDA));
         opnd = random_operand();
         if (!would_halt(op, opnd)) begin
            send_request(build_request(MODE_LOAD, shadow_pc, op, opnd));
         end
      end
   endtask

   task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                              input logic [VALUE_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         fault_count++;
      end
   endtask

   // Word store of both value extremes at the top of memory, an unused code, an unused mode.
   task automatic test_word_access();
      send_request(build_request(MODE_LOAD, ADDR_W'(LAST_WORD), OP_DAT, VALUE_MIN));
      send_request(build_request(MODE_LOAD, ADDR_W'(LAST_WORD - 1), CODE_UNUSED, VALUE_MAX));
      send_request(build_request(MODE_READ, ADDR_W'(LAST_WORD - 1), CODE_W'($urandom),
                                 $urandom));
      send_request(build_request(MODE_READ, ADDR_W'(LAST_WORD), CODE_W'($urandom), $urandom));
      send_request(random_request(MODE_UNUSED));
   endtask

   // Short program walking every instruction and the odd operands.
   task automatic test_instruction_set();
      send_request(build_request(MODE_LOAD, ADDR_W'(0), OP_LDA, LAST_WORD));      // acc = min
      send_request(build_request(MODE_LOAD, ADDR_W'(1), OP_SUB, LAST_WORD - 1));  // wraps
      send_request(build_request(MODE_LOAD, ADDR_W'(2), OP_STA, LAST_WORD - 2));
      send_request(build_request(MODE_LOAD, ADDR_W'(3), OP_LDA, -1));   // negative reads 0
      send_request(build_request(MODE_LOAD, ADDR_W'(4), OP_BRZ, 4));    // branch to itself
      send_request(build_request(MODE_LOAD, ADDR_W'(5), OP_STA, MEM_DEPTH));  // dropped
      send_request(build_request(MODE_LOAD, ADDR_W'(6), OP_SUB, VALUE_MAX));  // reads 0
      send_request(build_request(MODE_LOAD, ADDR_W'(7), OP_BRA, 9));
      send_request(build_request(MODE_LOAD, ADDR_W'(9), OP_LDA, LAST_WORD - 2));
      send_request(build_request(MODE_LOAD, ADDR_W'(10), OP_BRZ, VALUE_MIN)); // not taken
      repeat (10) send_request(random_request(MODE_EXEC));
      send_request(build_request(MODE_READ, ADDR_W'(LAST_WORD - 2), CODE_W'($urandom),
                                 $urandom));
   endtask

   // Random programs kept alive, salted with loads, reads and unused modes.
   task automatic test_random_program();
      int pick;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 300 && n < 480);
         pick = $urandom_range(99);
         if (pick < 45) begin
            keep_running();
            send_request(random_request(MODE_EXEC));
         end else if (pick < 70) begin
            send_request(build_request(MODE_LOAD, ADDR_W'($urandom), CODE_W'($urandom),
                                       random_operand()));
         end else if (pick < 82) begin
            send_request(random_request(MODE_READ));
         end else if (pick < 87) begin
            send_request(random_request(MODE_UNUSED));
         end else begin
            send_request(random_request(MODE_LOAD));
         end
      end
      calm = 1'b0;
   endtask

   // Stop the machine by one cause drawn at random, then prod it while halted.
   task automatic test_halt_and_after();
      logic signed [VALUE_W-1:0] target;
      case ($urandom_range(3))
         0: send_request(build_request(MODE_LOAD, shadow_pc, OP_HLT, $urandom));
         1: begin
            send_request(build_request(MODE_LOAD, shadow_pc,
                                       $urandom_range(1) ? OP_DAT : CODE_UNUSED, $urandom));
         end
         2: begin
            target = $urandom;
            if (names_word(target)) target = target + MEM_DEPTH;
            send_request(build_request(MODE_LOAD, shadow_pc,
                                       (shadow_acc == 0) ? OP_BRZ : OP_BRA, target));
         end
         default: begin
            // Step off the last word
            if (shadow_pc != LAST_WORD) begin
               send_request(build_request(MODE_LOAD, shadow_pc, OP_BRA, LAST_WORD));
               send_request(random_request(MODE_EXEC));
            end
            send_request(build_request(MODE_LOAD, ADDR_W'(LAST_WORD), OP_LDA,
                                       random_operand()));
         end
      endcase
      send_request(random_request(MODE_EXEC));
      repeat (3) send_request(random_request(MODE_EXEC));
      send_request(random_request(MODE_LOAD));
      send_request(random_request(MODE_READ));
      send_request(random_request(MODE_UNUSED));
   endtask

   // Compare each result transfer with the oldest prediction; idle the ready at random.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_rsp.size() == 0) begin
            $error("result transfer with no prediction waiting");
            fault_count++;
         end else begin
            want = predicted_rsp.pop_front();
            check_field("running", want.running, rsp_data.running);
            check_field("program_counter", want.program_counter, rsp_data.program_counter);
            check_field("accumulator", want.accumulator, rsp_data.accumulator);
            check_field("read_code", want.read_code, rsp_data.read_code);
            check_field("read_value", want.read_value, rsp_data.read_value);
         end
      end
      rsp_ready <= calm || ($urandom_range(99) >= 7);
   end

   // Give up when neither channel has moved for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** accumulator_cpu_step: FAILED **");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < MEM_DEPTH; i++) begin
         shadow_code[i]  = OP_DAT;
         shadow_value[i] = '0;
      end
      shadow_acc = '0;
      shadow_pc  = '0;
      shadow_run = 1'b1;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_word_access();
      test_instruction_set();
      test_random_program();
      test_halt_and_after();
      req_valid <= 1'b0;

      // Drain what is owed, then watch a little longer for stray results
      while (predicted_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0) begin
         $display("** accumulator_cpu_step: PASSED **");
      end else begin
         $display("** accumulator_cpu_step: FAILED **");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/acs_pkg.sv
src/acs_exec.sv
src/accumulator_cpu_step.sv
src/acs_checker.sv
tb/accumulator_cpu_step_test.sv
